[rtl/gha_pkg.sv]
`default_nettype none

package gha_pkg;

  // Default sizing of the slot memories.
  localparam int unsigned MaxSlotsDefault    = 1024;
  localparam int unsigned VersionBitsDefault = 16;

  // Fixed widths of the transaction fields.
  localparam int unsigned OpW       = 2;
  localparam int unsigned IdxFieldW = 10;
  localparam int unsigned VerFieldW = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned LiveW     = 11;

  typedef enum logic [OpW-1:0] {
    OpCreate  = 2'd0,
    OpDestroy = 2'd1,
    OpCheck   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StatOk      = 2'd0,
    StatFull    = 2'd1,
    StatInvalid = 2'd2
  } status_e;

endpackage : gha_pkg

`default_nettype wire

[rtl/gha_ram.sv]
`default_nettype none

module gha_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : gha_ram

`default_nettype wire

[rtl/generational_handle_allocator.sv]
// From an accepted start to the done_o strobe: a create that takes a fresh slot or finds the
// allocator full answers from idle, destroy and check pass through the check state, and a create
// that reuses a slot from the free stack passes the pop states (stack read, then version read).
// One transaction at a time: busy stays high until the result cycle, so no new one is
// accepted until the last is done. The receiver cannot stall; each result shows for one cycle.
// Reset clears registers, not memories; memory entries are never read before they are written.
`default_nettype none

module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned MaxSlots    = MaxSlotsDefault,
  parameter int unsigned VersionBits = VersionBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OpW-1:0]       op_i,
  input  wire logic [IdxFieldW-1:0] handle_index_i,
  input  wire logic [VerFieldW-1:0] handle_version_i,
  output logic                      done_o,
  output logic [StatusW-1:0]        status_o,
  output logic [IdxFieldW-1:0]      out_index_o,
  output logic [VerFieldW-1:0]      out_version_o,
  output logic                      is_valid_o,
  output logic [LiveW-1:0]          live_count_o
);

  localparam int unsigned IdxW  = $clog2(MaxSlots);
  localparam int unsigned CntW  = $clog2(MaxSlots + 1);
  localparam int unsigned CmpIW = (CntW > IdxFieldW) ? CntW : IdxFieldW;
  localparam int unsigned CmpVW = (VersionBits > VerFieldW) ? VersionBits : VerFieldW;

  typedef enum logic [1:0] {
    StIdle,
    StPop,
    StPopVer,
    StCheck
  } state_e;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [IdxFieldW-1:0]   idx_q, idx_d;
  logic [VerFieldW-1:0]   ver_q, ver_d;
  logic [IdxW-1:0]        slot_q, slot_d;
  logic [CntW-1:0]        fc_q, fc_d;
  logic [CntW-1:0]        hw_q, hw_d;
  logic                   done_q, done_d;
  logic [StatusW-1:0]     status_q, status_d;
  logic [IdxFieldW-1:0]   oidx_q, oidx_d;
  logic [VerFieldW-1:0]   over_q, over_d;
  logic                   valid_q, valid_d;
  logic [LiveW-1:0]       live_q, live_d;

  logic                   ver_we;
  logic [IdxW-1:0]        ver_waddr, ver_raddr;
  logic [VersionBits-1:0] ver_wdata, ver_rdata, ver_inc;
  logic                   stk_we;
  logic [IdxW-1:0]        stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic                   handle_ok;

  gha_ram #(
    .Width(VersionBits),
    .Depth(MaxSlots)
  ) u_version_ram (
    .clk_i  (clk_i),
    .we_i   (ver_we),
    .waddr_i(ver_waddr),
    .wdata_i(ver_wdata),
    .raddr_i(ver_raddr),
    .rdata_o(ver_rdata)
  );

  gha_ram #(
    .Width(IdxW),
    .Depth(MaxSlots)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  assign ver_inc   = ver_rdata + 1'b1;
  assign handle_ok = (CmpIW'(idx_q) < CmpIW'(hw_q)) &&
                     (CmpVW'(ver_rdata) == CmpVW'(ver_q));

  // The stack top is read speculatively; it is used only when the stack is not empty.
  assign stk_raddr = IdxW'(fc_q - 1'b1);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    idx_d    = idx_q;
    ver_d    = ver_q;
    slot_d   = slot_q;
    fc_d     = fc_q;
    hw_d     = hw_q;
    done_d   = 1'b0;
    status_d = status_q;
    oidx_d   = oidx_q;
    over_d   = over_q;
    valid_d  = valid_q;

    ver_we    = 1'b0;
    ver_waddr = IdxW'(idx_q);
    ver_wdata = ver_inc;
    ver_raddr = IdxW'(idx_q);
    stk_we    = 1'b0;
    stk_waddr = IdxW'(fc_q);
    stk_wdata = IdxW'(idx_q);

    unique case (state_q)
      StIdle: begin
        ver_raddr = IdxW'(handle_index_i);
        if (start) begin
          idx_d = handle_index_i;
          ver_d = handle_version_i;
          unique case (op_e'(op_i))
            OpCreate: begin
              op_d = OpCreate;
              if (fc_q != '0) begin
                fc_d    = fc_q - 1'b1;
                state_d = StPop;
              end else if (hw_q < CntW'(MaxSlots)) begin
                ver_we    = 1'b1;
                ver_waddr = IdxW'(hw_q);
                ver_wdata = VersionBits'(1);
                hw_d      = hw_q + 1'b1;
                status_d  = StatOk;
                oidx_d    = IdxFieldW'(hw_q);
                over_d    = VerFieldW'(1);
                valid_d   = 1'b1;
                done_d    = 1'b1;
              end else begin
                status_d = StatFull;
                oidx_d   = '0;
                over_d   = '0;
                valid_d  = 1'b0;
                done_d   = 1'b1;
              end
            end
            OpDestroy: begin
              op_d    = OpDestroy;
              state_d = StCheck;
            end
            default: begin
              op_d    = OpCheck;
              state_d = StCheck;
            end
          endcase
        end
      end

      StPop: begin
        // The popped slot addresses the version memory straight from the stack output.
        ver_raddr = stk_rdata;
        slot_d    = stk_rdata;
        state_d   = StPopVer;
      end

      StPopVer: begin
        status_d = StatOk;
        oidx_d   = IdxFieldW'(slot_q);
        over_d   = VerFieldW'(ver_rdata);
        valid_d  = 1'b1;
        done_d   = 1'b1;
        state_d  = StIdle;
      end

      StCheck: begin
        oidx_d = idx_q;
        over_d = ver_q;
        if (handle_ok) begin
          status_d = StatOk;
          valid_d  = 1'b1;
          if (op_q == OpDestroy) begin
            ver_we = 1'b1;
            // A push onto a full stack is dropped; the version still advances.
            if (fc_q < CntW'(MaxSlots)) begin
              stk_we = 1'b1;
              fc_d   = fc_q + 1'b1;
            end
          end
        end else begin
          status_d = StatInvalid;
          valid_d  = 1'b0;
        end
        done_d  = 1'b1;
        state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Repeated destroys of one slot can push the free count past the high-water mark.
    if (hw_d > fc_d) begin
      live_d = LiveW'(hw_d - fc_d);
    end else begin
      live_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      op_q     <= OpCreate;
      idx_q    <= '0;
      ver_q    <= '0;
      slot_q   <= '0;
      fc_q     <= '0;
      hw_q     <= '0;
      done_q   <= 1'b0;
      status_q <= '0;
      oidx_q   <= '0;
      over_q   <= '0;
      valid_q  <= 1'b0;
      live_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      ver_q    <= ver_d;
      slot_q   <= slot_d;
      fc_q     <= fc_d;
      hw_q     <= hw_d;
      done_q   <= done_d;
      status_q <= status_d;
      oidx_q   <= oidx_d;
      over_q   <= over_d;
      valid_q  <= valid_d;
      live_q   <= live_d;
    end
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_index_o  = oidx_q;
  assign out_version_o = over_q;
  assign is_valid_o   = valid_q;
  assign live_count_o = live_q;

endmodule : generational_handle_allocator

`default_nettype wire

[tb/sv/tb_generational_handle_allocator.sv]
`timescale 1ns / 100ps

module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int unsigned MaxSlots     = MaxSlotsDefault;
  localparam int          RandomItems  = 700;
  localparam int          RetiredDepth = 64;
  localparam int          DrainCycles  = 8;
  localparam int          StallLimit   = 2000;

  // The block treats the spare op code as a check.
  localparam logic [OpW-1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic [IdxFieldW-1:0] slot;
    logic [VerFieldW-1:0] version;
  } handle_t;

  typedef struct {
    status_e              status;
    logic [IdxFieldW-1:0] slot;
    logic [VerFieldW-1:0] version;
    logic                 valid;
    logic [LiveW-1:0]     live;
  } alloc_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OpW-1:0]       op_i;
  logic [IdxFieldW-1:0] handle_index_i;
  logic [VerFieldW-1:0] handle_version_i;
  logic                 done_o;
  logic [StatusW-1:0]   status_o;
  logic [IdxFieldW-1:0] out_index_o;
  logic [VerFieldW-1:0] out_version_o;
  logic                 is_valid_o;
  logic [LiveW-1:0]     live_count_o;

  // Allocator state as the testbench expects it.
  logic [VerFieldW-1:0] slot_version [MaxSlots];
  logic [IdxFieldW-1:0] free_slots [MaxSlots];
  int unsigned          free_count;
  int unsigned          high_water;

  alloc_result_t expected_results [$];
  handle_t       live_handles [$];
  handle_t       retired_handles [$];
  int            error_count;
  int            stall_cycles;

  generational_handle_allocator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .handle_index_i   (handle_index_i),
    .handle_version_i (handle_version_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_index_o      (out_index_o),
    .out_version_o    (out_version_o),
    .is_valid_o       (is_valid_o),
    .live_count_o     (live_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic alloc_result_t predict_allocation(logic [OpW-1:0] op,
      logic [IdxFieldW-1:0] idx, logic [VerFieldW-1:0] ver);
    alloc_result_t r;
    logic          hit;
    r.status  = StatOk;
    r.slot    = idx;
    r.version = ver;
    r.valid   = 1'b0;
    hit = (int'(idx) < high_water) && (slot_version[idx] == ver);
    case (op)
      OpCreate: begin
        if (free_count > 0) begin
          free_count--;
          r.slot    = free_slots[free_count];
          r.version = slot_version[r.slot];
          r.valid   = 1'b1;
        end else if (high_water < MaxSlots) begin
          r.slot    = IdxFieldW'(high_water);
          r.version = VerFieldW'(1);
          r.valid   = 1'b1;
          slot_version[high_water] = VerFieldW'(1);
          high_water++;
        end else begin
          r.status  = StatFull;
          r.slot    = '0;
          r.version = '0;
        end
      end
      OpDestroy: begin
        if (hit) begin
          slot_version[idx] = slot_version[idx] + VerFieldW'(1);
          // A push onto a full stack is dropped, but the version still moves on.
          if (free_count < MaxSlots) begin
            free_slots[free_count] = idx;
            free_count++;
          end
          r.valid = 1'b1;
        end else begin
          r.status = StatInvalid;
        end
      end
      default: begin
        if (hit) r.valid = 1'b1;
        else r.status = StatInvalid;
      end
    endcase
    r.live = (free_count >= high_water) ? '0 : LiveW'(high_water - free_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("ERROR %0t: %s expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  task automatic send_request(logic [OpW-1:0] op, logic [IdxFieldW-1:0] idx,
      logic [VerFieldW-1:0] ver);
    alloc_result_t want;
    handle_t       made;
    start            <= 1'b1;
    op_i             <= op;
    handle_index_i   <= idx;
    handle_version_i <= ver;
    do @(posedge clk_i); while (busy);
    want = predict_allocation(op, idx, ver);
    expected_results.insert(expected_results.size(), want);
    if (want.valid) begin
      if (op == OpCreate) begin
        made.slot    = want.slot;
        made.version = want.version;
        live_handles.insert(live_handles.size(), made);
      end else if (op == OpDestroy) begin
        made.slot    = idx;
        made.version = ver;
        retired_handles.insert(retired_handles.size(), made);
        if (retired_handles.size() > RetiredDepth) void'(retired_handles.pop_front());
      end
    end
  endtask

  task automatic sender_pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Picks a handle that still matches its slot, dropping stale entries on the way.
  function automatic bit pick_live_handle(output handle_t h);
    int i;
    while (live_handles.size() != 0) begin
      i = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[i];
      if (int'(h.slot) < high_water && slot_version[h.slot] == h.version) return 1'b1;
      live_handles.delete(i);
    end
    return 1'b0;
  endfunction

  task automatic send_random_request();
    int      pick;
    handle_t h;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_request(OpCreate, IdxFieldW'($urandom), VerFieldW'($urandom));
    end else if (pick < 70) begin
      if (pick_live_handle(h))
        send_request((pick < 55) ? OpDestroy : OpCheck, h.slot, h.version);
      else
        send_request(OpCreate, IdxFieldW'($urandom), VerFieldW'($urandom));
    end else if (pick < 80 && retired_handles.size() != 0) begin
      h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
      send_request($urandom_range(0, 1) ? OpDestroy : OpCheck, h.slot, h.version);
    end else if (pick < 90 || high_water == 0) begin
      send_request(OpW'($urandom_range(0, 3)), IdxFieldW'($urandom_range(0, 1023)),
                   VerFieldW'($urandom_range(0, 65535)));
    end else begin
      // Low versions on slots in use, so that a guess now and then hits.
      send_request($urandom_range(0, 1) ? OpDestroy : OpSpare,
                   IdxFieldW'($urandom_range(0, high_water - 1)),
                   VerFieldW'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_directed();
    send_request(OpCheck, 10'd0, 16'd0);
    send_request(OpCreate, 10'd0, 16'd0);
    send_request(OpCreate, 10'd1023, 16'hFFFF);
    send_request(OpCheck, 10'd0, 16'd1);
    send_request(OpCheck, 10'd1, 16'd2);
    send_request(OpCheck, 10'd1023, 16'hFFFF);
    send_request(OpSpare, 10'd0, 16'd1);
    send_request(OpDestroy, 10'd0, 16'd1);
    // A freed slot still passes the check while its version matches.
    send_request(OpCheck, 10'd0, 16'd2);
    send_request(OpDestroy, 10'd0, 16'd1);
    send_request(OpDestroy, 10'd0, 16'd2);
    // More entries on the stack than slots handed out: the live count holds at zero.
    send_request(OpDestroy, 10'd1, 16'd1);
    send_request(OpCreate, 10'd0, 16'd0);
    send_request(OpCreate, 10'd0, 16'd0);
    send_request(OpCreate, 10'd0, 16'd0);
    send_request(OpCreate, 10'd0, 16'd0);
    send_request(OpDestroy, 10'd2, 16'hFFFF);
    send_request(OpDestroy, 10'd1023, 16'd0);
  endtask

  task automatic test_random_traffic();
    bit calm;
    calm = 1'b0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n % 400 == 399) wait_for_results();
      else if (!calm && $urandom_range(0, 5) == 0) sender_pause($urandom_range(1, 13));
      send_random_request();
    end
  endtask

  task automatic test_fill_to_full();
    while (free_count != 0 || high_water < MaxSlots)
      send_request(OpCreate, IdxFieldW'($urandom), VerFieldW'($urandom));
    send_request(OpCreate, 10'd5, 16'd7);
    send_request(OpCreate, 10'd1023, 16'hFFFF);
    send_request(OpCheck, IdxFieldW'(MaxSlots - 1), slot_version[MaxSlots - 1]);
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no pending transaction, status", 0, status_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (out_index_o !== want.slot) report_mismatch("out_index", want.slot, out_index_o);
        if (out_version_o !== want.version)
          report_mismatch("out_version", want.version, out_version_o);
        if (is_valid_o !== want.valid) report_mismatch("is_valid", want.valid, is_valid_o);
        if (live_count_o !== want.live)
          report_mismatch("live_count", want.live, live_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    error_count      = 0;
    stall_cycles     = 0;
    free_count       = 0;
    high_water       = 0;
    for (int i = 0; i < MaxSlots; i++) begin
      slot_version[i] = '0;
      free_slots[i]   = '0;
    end
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    op_i             <= OpCreate;
    handle_index_i   <= '0;
    handle_version_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_fill_to_full();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
